FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true outside reset
`define GBD_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: rtl/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg
// shared types, constants and width helpers of the 2x2 gray downscaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbd_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int SRC_WIDTH_RESET  = 640;
    localparam int SRC_HEIGHT_RESET = 480;

    localparam int PIX_W      = 8;
    localparam int PAIR_W     = 9;
    localparam int SUM_W      = 11;
    localparam int SRC_W_W    = 13;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // rounding offsets for the two-pixel and four-pixel means
    localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1);
    localparam logic [SUM_W-1:0] RND_QUAD = SUM_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-result control and pair sum handed from the front end to the averager
    typedef struct packed {
        logic              single;
        logic              odd_row;
        logic              row_end;
        logic              frame_end;
        logic [PAIR_W-1:0] pair;
    } op_t;

    function automatic int col_width(input int max_width);
        return (max_width > 1) ? $clog2(max_width) : 1;
    endfunction

    function automatic int line_depth(input int max_width);
        return (max_width + 1) >> 1;
    endfunction

    function automatic int addr_width(input int max_width);
        return (line_depth(max_width) > 1) ? $clog2(line_depth(max_width)) : 1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gbd_line_buf.sv
// ----------------------------------------------------------------------------
// gbd_line_buf
// single-port-per-direction line memory for horizontal pair sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbd_line_buf #(
    parameter  int MAX_WIDTH  = gbd_pkg::MAX_WIDTH_DEF,
    localparam int LINE_DEPTH = gbd_pkg::line_depth(MAX_WIDTH),
    localparam int ADDR_W     = gbd_pkg::addr_width(MAX_WIDTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [gbd_pkg::PAIR_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    output logic      [gbd_pkg::PAIR_W-1:0] rd_data_reg
);
    import gbd_pkg::*;

    logic [PAIR_W-1:0] mem [LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // even rows only write, odd rows only read
    `GBD_ASSERT_NEVER(a_no_rw_same_cycle, aclk, aresetn, wr_en && rd_en, "line read and write collide")
    `GBD_ASSERT(a_wr_addr_range, aclk, aresetn, !wr_en || (32'(wr_addr) < LINE_DEPTH), "line write out of range")

endmodule

`default_nettype wire

FILE: rtl/gbd_ctrl.sv
// ----------------------------------------------------------------------------
// gbd_ctrl
// frame geometry registers, raster counters and pair formation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbd_ctrl #(
    parameter  int MAX_WIDTH = gbd_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = gbd_pkg::col_width(MAX_WIDTH),
    localparam int ADDR_W    = gbd_pkg::addr_width(MAX_WIDTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [gbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_accept,
    input  wire logic [gbd_pkg::PIX_W-1:0]      pixel,
    output logic                               issue,
    output gbd_pkg::op_t                       op,
    output logic                               wr_en,
    output logic      [ADDR_W-1:0]             wr_addr,
    output logic      [gbd_pkg::PAIR_W-1:0]     wr_data,
    output logic                               rd_en,
    output logic      [ADDR_W-1:0]             rd_addr
);
    import gbd_pkg::*;

    localparam int WIDTH_RESET = (SRC_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : SRC_WIDTH_RESET;

    logic [COL_W-1:0] width_m1_reg;
    logic [ROW_W-1:0] height_m1_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] held_reg;

    logic [SRC_W_W-1:0] cfg_w;
    logic [COL_W-1:0]   width_m1_next;
    logic [ROW_W-1:0]   height_m1_next;

    logic              odd_col;
    logic              odd_row;
    logic              last_col;
    logic              last_row;
    logic              single;
    logic              pair_pos;
    logic [PAIR_W-1:0] pair;
    logic [ADDR_W-1:0] idx;

    // zero means one, widths above the line capacity saturate (only the low SRC_W_W bits of the width count)
    always_comb begin
        cfg_w = cfg_data[SRC_W_W-1:0];
        if (cfg_w == '0) begin
            width_m1_next = '0;
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            width_m1_next = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_m1_next = COL_W'(32'(cfg_w) - 32'd1);
        end
        if (cfg_data == '0) begin
            height_m1_next = '0;
        end else begin
            height_m1_next = cfg_data - 16'd1;
        end
    end

    always_comb begin
        odd_col  = col_reg[0];
        odd_row  = row_reg[0];
        last_col = (col_reg == width_m1_reg);
        last_row = (row_reg == height_m1_reg);
        single   = !odd_col && last_col;
        pair_pos = odd_col || single;
        pair     = single ? {1'b0, pixel} : ({1'b0, held_reg} + {1'b0, pixel});
        idx      = ADDR_W'(col_reg >> 1);

        wr_en    = in_accept && pair_pos && !odd_row;
        wr_addr  = idx;
        wr_data  = pair;
        rd_en    = in_accept && pair_pos && odd_row;
        rd_addr  = idx;

        issue        = in_accept && pair_pos && (odd_row || last_row);
        op.single    = single;
        op.odd_row   = odd_row;
        op.row_end   = last_col;
        op.frame_end = last_col && last_row;
        op.pair      = pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg  <= COL_W'(WIDTH_RESET - 1);
            height_m1_reg <= ROW_W'(SRC_HEIGHT_RESET - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            held_reg      <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:  width_m1_reg  <= width_m1_next;
                REG_SRC_HEIGHT: height_m1_reg <= height_m1_next;
                default:        ;
            endcase
            // any write restarts the frame
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            if (!pair_pos) begin
                held_reg <= pixel;
            end
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 16'd1;
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    `GBD_ASSERT(a_col_in_frame, aclk, aresetn, col_reg <= width_m1_reg, "column past frame width")
    `GBD_ASSERT(a_row_in_frame, aclk, aresetn, row_reg <= height_m1_reg, "row past frame height")

endmodule

`default_nettype wire

FILE: rtl/gbd_avg.sv
// ----------------------------------------------------------------------------
// gbd_avg
// combines pair sums with the line buffer and drives the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbd_avg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      issue,
    input  wire gbd_pkg::op_t              op,
    input  wire logic [gbd_pkg::PAIR_W-1:0] line_data,
    output logic                           up_ready,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [gbd_pkg::PIX_W-1:0]  m_out_pixel,
    output logic                           m_row_end,
    output logic                           m_frame_end
);
    import gbd_pkg::*;

    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_out_pixel_reg;
    logic             m_row_end_reg;
    logic             m_frame_end_reg;

    logic             advance;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] rounded;

    assign advance  = !m_valid_reg || m_ready;
    assign up_ready = !s1_valid_reg || advance;

    // a last even row pairs with itself
    always_comb begin
        sum = SUM_W'(s1_op_reg.odd_row ? line_data : s1_op_reg.pair) + SUM_W'(s1_op_reg.pair);
        if (s1_op_reg.single) begin
            rounded = (sum + RND_HALF) >> 1;
        end else begin
            rounded = (sum + RND_QUAD) >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (up_ready) begin
                s1_valid_reg <= issue;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && issue) begin
            s1_op_reg <= op;
        end
        if (advance && s1_valid_reg) begin
            m_out_pixel_reg <= rounded[PIX_W-1:0];
            m_row_end_reg   <= s1_op_reg.row_end;
            m_frame_end_reg <= s1_op_reg.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_pixel = m_out_pixel_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

    `GBD_ASSERT(a_s1_holds, aclk, aresetn, (s1_valid_reg && !advance) |=> s1_valid_reg, "stage lost under stall")
    `GBD_ASSERT(a_frame_end_row_end, aclk, aresetn, !m_valid_reg || !m_frame_end_reg || m_row_end_reg, "frame end without row end")

endmodule

`default_nettype wire

FILE: rtl/gray_2x2_box_downscale_top.sv
// ----------------------------------------------------------------------------
// gray_2x2_box_downscale_top
// 2x2 box-filter downscaler for a raster stream of 8-bit gray pixels
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while the output is not stalled and gives
// one output beat per 2x2 block, (a+b+c+d+2)>>2, so the output frame is
// ceil(w/2) x ceil(h/2). An odd last column gives the vertical mean
// (a+b+1)>>1, an odd last row is paired with itself. The even row writes
// each horizontal pair sum into the line memory and the odd row reads it
// back, one memory access per pixel pair, so a beat can be accepted every
// clock unless the output stalls. A result is registered in the line read
// and stage register, then in the output register. The line memory holds
// ceil(MAX_WIDTH/2) pair sums and needs no clearing after reset. Configuration
// writes are always taken, act at once and restart the frame at row 0,
// column 0; width 0 or height 0 count as 1, widths from MAX_WIDTH+1 to 8191 saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gray_2x2_box_downscale_top #(
    parameter int MAX_WIDTH = gbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gbd_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [gbd_pkg::PIX_W-1:0]      s_pixel,
    // downscaled output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [gbd_pkg::PIX_W-1:0]      m_out_pixel,
    output logic                               m_row_end,
    output logic                               m_frame_end
);
    import gbd_pkg::*;

    localparam int ADDR_W = addr_width(MAX_WIDTH);

    logic              in_accept;
    logic              issue;
    op_t               op;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PAIR_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PAIR_W-1:0] line_data;
    logic              up_ready;

    // registers are plain flops, a write never has to wait
    assign cfg_ready = 1'b1;

    // the input stalls only when both the averaging stage and the output are full and the output is not taken
    assign s_ready   = up_ready;
    assign in_accept = s_valid && s_ready;

    // geometry, counters and horizontal pair sums
    gbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .pixel     (s_pixel),
        .issue     (issue),
        .op        (op),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // pair sums of the last even row
    gbd_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data_reg (line_data)
    );

    // rounding and output register
    gbd_avg u_avg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .op          (op),
        .line_data   (line_data),
        .up_ready    (up_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire
